/* rtl/lrjs_pkg.sv */
// Package: command, state and route codes and the cell control bundle.
package lrjs_pkg;

  // Command codes carried by an input beat
  localparam logic CMD_ADMIT    = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  // Outgoing process states
  localparam logic [1:0] PST_READY    = 2'd0;
  localparam logic [1:0] PST_BLOCKED  = 2'd1;
  localparam logic [1:0] PST_FINISHED = 2'd2;
  localparam logic [1:0] PST_INVALID  = 2'd3;

  // Route codes reported in a result beat
  localparam logic [2:0] ROUTE_NONE     = 3'd0;
  localparam logic [2:0] ROUTE_READY    = 3'd1;
  localparam logic [2:0] ROUTE_BLOCKED  = 3'd2;
  localparam logic [2:0] ROUTE_FINISHED = 3'd3;
  localparam logic [2:0] ROUTE_BAD      = 3'd4;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic write;  // load the tail cell from the write bus
    logic shift;  // close the gap behind the selected cell
    logic start;  // launch a scan wave at the head cell
  } cell_ctl_t;

endpackage

/* rtl/lrjs_in_if.sv */
// Interface: input channel carrying commands and process records.
interface lrjs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        proc_present;
  logic [15:0] proc_id;
  logic [31:0] proc_remaining;
  logic [1:0]  proc_state;

  modport source (output valid, command, proc_present, proc_id, proc_remaining, proc_state,
                  input ready);
  modport sink   (input valid, command, proc_present, proc_id, proc_remaining, proc_state,
                  output ready);
endinterface

/* rtl/lrjs_out_if.sv */
// Interface: result channel carrying selection, routing and table status.
interface lrjs_out_if;
  logic        valid;
  logic        ready;
  logic        selected_valid;
  logic [15:0] selected_id;
  logic [31:0] selected_remaining;
  logic [2:0]  route;
  logic        overflow;
  logic [4:0]  ready_count;

  modport source (output valid, selected_valid, selected_id, selected_remaining, route,
                  overflow, ready_count, input ready);
  modport sink   (input valid, selected_valid, selected_id, selected_remaining, route,
                  overflow, ready_count, output ready);
endinterface

/* rtl/longest_remaining_job_select_unit.sv */
// Top level: longest-remaining-job selector built as a chain of table cells.
//
// Usage:
//   item   (sink)   : one beat per command. An admit appends a process to the
//                     ready table; a schedule routes an optional outgoing
//                     process by its state, appends it if ready, then removes
//                     and returns the entry with the greatest remaining time
//                     (earliest entry on a tie).
//   result (source) : exactly one beat per item: selection, route code,
//                     overflow flag and the table fill after the item.
//   Sequencing: an admit goes from idle straight to the done state, which
//   loads the result register and returns to idle to take the next item.
//   A schedule launches a search wave at the head cell that walks all
//   QUEUE_DEPTH cells one cell per cycle, captures the winner once the wave
//   has left the last cell, shifts the cells behind it forward, then loads
//   the result register in the done state and returns to idle to take the
//   next item; an empty table skips the shift step.
//   Reset (rst, synchronous) empties the table and drops any held result.
//   Stall: the result register holds its beat while result.ready is low; the
//   next item is still taken and worked, then waits for the held beat to drain.
module longest_remaining_job_select_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst,
  lrjs_in_if.sink    item,
  lrjs_out_if.source result
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       sel_idx;
  logic                   sel_valid;
  logic [15:0]            sel_id;
  logic [TIME_BITS-1:0]   sel_rem;
  logic [2:0]             route;
  logic                   ovf;

  lrjs_pkg::cell_ctl_t    ctl;
  logic                   accept;
  logic                   push_req;
  logic                   push_ok;
  logic [2:0]             route_next;
  logic [TIME_BITS-1:0]   wr_rem;
  logic [TIME_BITS+31:0]  rem_in_wide;
  logic [TIME_BITS+31:0]  rem_out_wide;
  logic [CNT_W+4:0]       count_wide;
  logic                   out_free;

  // Per-cell wiring; index QUEUE_DEPTH is the end of the search wave
  logic [15:0]            cell_id   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   cell_rem  [QUEUE_DEPTH];
  logic [15:0]            nb_id     [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]   nb_rem    [QUEUE_DEPTH];
  logic                   tok       [QUEUE_DEPTH+1];
  logic                   found     [QUEUE_DEPTH+1];
  logic [TIME_BITS-1:0]   best_rem  [QUEUE_DEPTH+1];
  logic [15:0]            best_id   [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]       best_idx  [QUEUE_DEPTH+1];

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;

  // Fit the 32-bit time field to the stored width and back
  assign rem_in_wide  = {{TIME_BITS{1'b0}}, item.proc_remaining};
  assign wr_rem       = rem_in_wide[TIME_BITS-1:0];
  assign rem_out_wide = {32'd0, sel_rem};
  assign count_wide   = {5'd0, count};

  // An admit, or an outgoing ready process on a schedule, goes to the tail
  assign push_req = item.proc_present &&
                    ((item.command == lrjs_pkg::CMD_ADMIT) ||
                     (item.proc_state == lrjs_pkg::PST_READY));
  assign push_ok  = push_req && (count != FULL);

  always_comb begin
    route_next = lrjs_pkg::ROUTE_NONE;
    if ((item.command == lrjs_pkg::CMD_SCHEDULE) && item.proc_present) begin
      case (item.proc_state)
        lrjs_pkg::PST_READY:    route_next = lrjs_pkg::ROUTE_READY;
        lrjs_pkg::PST_BLOCKED:  route_next = lrjs_pkg::ROUTE_BLOCKED;
        lrjs_pkg::PST_FINISHED: route_next = lrjs_pkg::ROUTE_FINISHED;
        default:                route_next = lrjs_pkg::ROUTE_BAD;
      endcase
    end
  end

  always_comb begin
    ctl.write = accept && push_ok;
    ctl.start = (state == S_LAUNCH);
    ctl.shift = (state == S_SHIFT);
  end

  // Head of the search wave: empty candidate
  assign tok[0]      = ctl.start;
  assign found[0]    = 1'b0;
  assign best_rem[0] = '0;
  assign best_id[0]  = '0;
  assign best_idx[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nb_id[i]  = cell_id[i];
      assign nb_rem[i] = cell_rem[i];
    end else begin : g_body
      assign nb_id[i]  = cell_id[i+1];
      assign nb_rem[i] = cell_rem[i+1];
    end

    lrjs_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .IDX         (i),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .count        (count),
      .sel_idx      (sel_idx),
      .wr_id        (item.proc_id),
      .wr_rem       (wr_rem),
      .nb_id        (nb_id[i]),
      .nb_rem       (nb_rem[i]),
      .own_id       (cell_id[i]),
      .own_rem      (cell_rem[i]),
      .tok_in       (tok[i]),
      .found_in     (found[i]),
      .best_rem_in  (best_rem[i]),
      .best_id_in   (best_id[i]),
      .best_idx_in  (best_idx[i]),
      .tok_out      (tok[i+1]),
      .found_out    (found[i+1]),
      .best_rem_out (best_rem[i+1]),
      .best_id_out  (best_id[i+1]),
      .best_idx_out (best_idx[i+1])
    );
  end

  // Sequencer: state, fill count and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      // Drop a drained beat; in S_DONE the reload below decides
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            route     <= route_next;
            ovf       <= push_req && !push_ok;
            sel_valid <= 1'b0;
            sel_id    <= '0;
            sel_rem   <= '0;
            if (push_ok) begin
              count <= count + ONE;
            end
            state <= (item.command == lrjs_pkg::CMD_SCHEDULE) ? S_LAUNCH : S_DONE;
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          // Wave has left the last cell: capture the winner
          if (tok[QUEUE_DEPTH]) begin
            sel_valid <= found[QUEUE_DEPTH];
            sel_id    <= found[QUEUE_DEPTH] ? best_id[QUEUE_DEPTH] : '0;
            sel_rem   <= found[QUEUE_DEPTH] ? best_rem[QUEUE_DEPTH] : '0;
            sel_idx   <= best_idx[QUEUE_DEPTH];
            state     <= found[QUEUE_DEPTH] ? S_SHIFT : S_DONE;
          end
        end
        S_SHIFT: begin
          count <= count - ONE;
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold here while an earlier beat still waits at the output
          if (out_free) begin
            result.valid              <= 1'b1;
            result.selected_valid     <= sel_valid;
            result.selected_id        <= sel_id;
            result.selected_remaining <= rem_out_wide[31:0];
            result.route              <= route;
            result.overflow           <= ovf;
            result.ready_count        <= count_wide[4:0];
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("ready table fill count above depth");

  // A shift only follows a scan that found an entry in a non-empty table
  a_shift_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (sel_valid && (count != '0)))
    else $error("compaction without a selected entry");

  // The search wave only reaches the end while the sequencer waits for it
  a_wave_end: assert property (@(posedge clk) disable iff (rst)
    tok[QUEUE_DEPTH] |-> (state == S_WAIT))
    else $error("search wave ended outside the wait state");

  // A new item is only taken when the table change of the last one is done
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == S_LAUNCH) || (state == S_DONE)))
    else $error("accepted item did not start a launch or finish");

endmodule

/* rtl/lrjs_cell.sv */
// Module: one table slot plus one stage of the max-search wave.
module lrjs_cell #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  parameter int IDX         = 0,
  parameter int IDX_W       = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrjs_pkg::cell_ctl_t   ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [IDX_W-1:0]      sel_idx,
  input  logic [15:0]           wr_id,
  input  logic [TIME_BITS-1:0]  wr_rem,
  input  logic [15:0]           nb_id,
  input  logic [TIME_BITS-1:0]  nb_rem,
  output logic [15:0]           own_id,
  output logic [TIME_BITS-1:0]  own_rem,
  input  logic                  tok_in,
  input  logic                  found_in,
  input  logic [TIME_BITS-1:0]  best_rem_in,
  input  logic [15:0]           best_id_in,
  input  logic [IDX_W-1:0]      best_idx_in,
  output logic                  tok_out,
  output logic                  found_out,
  output logic [TIME_BITS-1:0]  best_rem_out,
  output logic [15:0]           best_id_out,
  output logic [IDX_W-1:0]      best_idx_out
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam bit               IS_LAST = (IDX == QUEUE_DEPTH - 1);

  logic occupied;
  logic take_own;

  assign occupied = (MY_CNT < count);
  // Earlier entries win ties: replace only on strictly greater
  assign take_own = occupied && (!found_in || (own_rem > best_rem_in));

  // Slot storage: tail write or gap-closing shift from the next cell
  always_ff @(posedge clk) begin
    if (ctl.write && (count == MY_CNT)) begin
      own_id  <= wr_id;
      own_rem <= wr_rem;
    end else if (ctl.shift && !IS_LAST && (MY_IDX >= sel_idx)) begin
      own_id  <= nb_id;
      own_rem <= nb_rem;
    end
  end

  // Search wave: advance one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      found_out    <= 1'b1;
      best_rem_out <= own_rem;
      best_id_out  <= own_id;
      best_idx_out <= MY_IDX;
    end else begin
      found_out    <= found_in;
      best_rem_out <= best_rem_in;
      best_id_out  <= best_id_in;
      best_idx_out <= best_idx_in;
    end
  end

endmodule
